// ===== design/plt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ping link test package
// Shared types, codes and helper functions of the two-radio ping link test.
// ----------------------------------------------------------------------------
package plt_pkg;

    localparam int HIST_BINS    = 16;
    localparam int HIST_BIN_W   = $clog2(HIST_BINS);
    localparam int RADIOS       = 2;
    localparam int STAT_ADDR_W  = $clog2(RADIOS);
    localparam int HIST_DEPTH   = RADIOS * HIST_BINS;
    localparam int HIST_ADDR_W  = $clog2(HIST_DEPTH);

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TIMEOUT_US = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIMEOUT_US  = 2'd2;

    localparam logic [15:0] RST_INTERVAL_MS      = 16'd1000;
    localparam logic [31:0] RST_SHORT_TIMEOUT_US = 32'd500000;
    localparam logic [31:0] RST_LONG_TIMEOUT_US  = 32'd2000000;

    localparam logic [31:0] BIN_WIDTH_US     = 32'd480000;
    localparam logic [31:0] RESTART_DELAY_US = 32'd500000;
    localparam logic [31:0] US_PER_MS        = 32'd1000;

    localparam logic [7:0] ROLE_PONG      = 8'h02;
    localparam logic [7:0] RADIO_ID_SHORT = 8'd1;
    localparam logic [7:0] RADIO_ID_LONG  = 8'd2;

    localparam logic [STAT_ADDR_W-1:0] RADIO_SHORT = 1'b0;
    localparam logic [STAT_ADDR_W-1:0] RADIO_LONG  = 1'b1;

    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_SHORT_RX = 3'd1;
    localparam logic [2:0] KIND_LONG_RX  = 3'd2;
    localparam logic [2:0] KIND_LONG_CRC = 3'd3;
    localparam logic [2:0] KIND_READ     = 3'd4;
    localparam logic [2:0] KIND_RESTART  = 3'd5;
    localparam logic [2:0] KIND_CLEAR    = 3'd6;

    localparam logic [1:0] SEND_NONE  = 2'd0;
    localparam logic [1:0] SEND_SHORT = 2'd1;
    localparam logic [1:0] SEND_LONG  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SEND_S = 3'd1,
        PH_WAIT_S = 3'd2,
        PH_SEND_L = 3'd3,
        PH_WAIT_L = 3'd4
    } t_phase;

    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        now_us;
        logic               frame_ok;
        logic [7:0]         pkt_role;
        logic [7:0]         pkt_radio;
        logic [15:0]        pkt_seq;
        logic signed [15:0] signal_rssi;
        logic signed [7:0]  signal_snr;
        logic [7:0]         signal_lqi;
        logic               stats_select;
        logic [3:0]         hist_bin;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        send_ping;
        logic [15:0]       ping_seq;
        logic [2:0]        link_state;
        logic [31:0]       total_count;
        logic [31:0]       ok_count;
        logic [31:0]       rtt_min;
        logic [31:0]       rtt_max;
        logic [63:0]       rtt_total;
        logic [31:0]       bin_count;
        logic signed [7:0] recent_rssi;
        logic signed [7:0] recent_snr;
        logic [7:0]        recent_lqi;
    } t_out_item;

    typedef struct packed {
        logic [7:0] lqi;
        logic [7:0] snr;
        logic [7:0] rssi;
    } t_quality;

    typedef struct packed {
        logic [31:0] attempts;
        logic [31:0] successes;
        logic [31:0] min_trip;
        logic [31:0] max_trip;
        logic [63:0] trip_sum;
        t_quality    quality;
    } t_stats;

    // Histogram bin of a round trip, saturated at the last bin.
    function automatic logic [HIST_BIN_W-1:0] rtt_bin(input logic [31:0] rtt);
        int cnt;
        cnt = 0;
        for (int k = 1; k < HIST_BINS; k++) begin
            if (rtt >= 32'(k) * BIN_WIDTH_US) begin
                cnt = cnt + 1;
            end
        end
        return HIST_BIN_W'(cnt);
    endfunction

    // Low byte of rssi / -10 truncated toward zero, by reciprocal multiply.
    function automatic logic [7:0] rssi_div_neg10(input logic signed [15:0] rssi);
        logic [15:0] mag;
        logic [32:0] prod;
        logic [15:0] quot;
        mag  = rssi[15] ? 16'(-rssi) : 16'(rssi);
        prod = 33'(mag) * 33'd52429;
        quot = 16'(prod >> 19);
        return rssi[15] ? quot[7:0] : 8'(8'd0 - quot[7:0]);
    endfunction

endpackage
`default_nettype wire

// ===== design/plt_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ping link test input channel
// Valid/ready channel that carries one tick, radio event, read, restart or clear per transfer.
// ----------------------------------------------------------------------------
interface plt_in_if;
    logic              valid;
    logic              ready;
    plt_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/plt_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ping link test output channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface plt_out_if;
    logic               valid;
    logic               ready;
    plt_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/plt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ping link test statistics RAM
// One write port and two registered read ports, with per-entry valid bits
// that clear at once and a bypass of the write that lands with a read.
// ----------------------------------------------------------------------------
module plt_ram #(
    parameter int DEPTH  = 2,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_clear,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr_a,
    input  wire logic [ADDR_W-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]  o_rdata_a,
    output logic      [WIDTH-1:0]  o_rdata_b
);
    logic [WIDTH-1:0]  mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [WIDTH-1:0]  r_q_a;
    logic [WIDTH-1:0]  r_q_b;
    logic [ADDR_W-1:0] r_addr_a;
    logic [ADDR_W-1:0] r_addr_b;
    logic              r_fw_valid;
    logic [ADDR_W-1:0] r_fw_addr;
    logic [WIDTH-1:0]  r_fw_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q_a <= mem[i_raddr_a];
            r_q_b <= mem[i_raddr_b];
            r_addr_a <= i_raddr_a;
            r_addr_b <= i_raddr_b;
            r_fw_addr <= i_waddr;
            r_fw_data <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fw_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_fw_valid <= i_we;
            end
        end
    end

    always_comb begin
        if (!r_valid[r_addr_a]) begin
            o_rdata_a = '0;
        end else if (r_fw_valid && r_fw_addr == r_addr_a) begin
            o_rdata_a = r_fw_data;
        end else begin
            o_rdata_a = r_q_a;
        end
        if (!r_valid[r_addr_b]) begin
            o_rdata_b = '0;
        end else if (r_fw_valid && r_fw_addr == r_addr_b) begin
            o_rdata_b = r_fw_data;
        end else begin
            o_rdata_b = r_q_b;
        end
    end
endmodule
`default_nettype wire

// ===== design/ping_link_test_with_rtt_stats.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ping link test with round-trip statistics
// Master side of a two-radio ping-pong link test with per-radio statistics.
//
//   Channel   Direction  Transfer contents
//   i_in      in         one tick, radio event, read, restart or clear
//   o_out     out        ping request, link state and selected statistics
//   i_cfg_*   in         interval and timeout registers, write only
//
// One item is accepted per cycle while i_in.ready is high; its result passes
// the statistics stage register and the output register to reach o_out.
// Statistics and histogram sit in two RAMs, read when an item is accepted
// and written back when the item leaves the statistics stage, with the
// write of that cycle bypassed.
// Reset is synchronous; valid bits clear the RAMs at once, with no sweep.
// A stalled result holds in the output register while one more item enters;
// the input then stalls until the result transfers.
// ----------------------------------------------------------------------------
module ping_link_test_with_rtt_stats (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    plt_in_if.sink                                 i_in,
    plt_out_if.source                              o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [plt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [plt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int SAW = plt_pkg::STAT_ADDR_W;
    localparam int HAW = plt_pkg::HIST_ADDR_W;

    logic [15:0] r_interval_ms;
    logic [31:0] r_short_timeout_us;
    logic [31:0] r_long_timeout_us;

    plt_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_short_seq, n_short_seq;
    logic [15:0] r_long_seq, n_long_seq;
    logic [31:0] r_ping_time, n_ping_time;
    logic [31:0] r_next_due, n_next_due;

    logic              in_ready;
    logic              accept;
    logic              s1_adv;
    logic              s1_fire;
    logic [31:0]       elapsed;
    logic [31:0]       due_gap;
    logic              short_good;
    logic              long_good;
    logic [1:0]        send;
    logic [15:0]       pseq;
    logic              rec;
    logic              clr;
    logic [SAW-1:0]    rec_radio;
    logic              rec_good;
    logic [31:0]       rec_rtt;
    plt_pkg::t_quality rec_q;
    logic [HAW-1:0]    hist_waddr;
    logic [HAW-1:0]    hist_raddr;
    logic              hb_ok;

    logic              r_s1_valid;
    logic              r_s1_rec;
    logic              r_s1_clr;
    logic [SAW-1:0]    r_s1_radio;
    logic              r_s1_good;
    logic [31:0]       r_s1_rtt;
    plt_pkg::t_quality r_s1_q;
    logic [SAW-1:0]    r_s1_sel;
    logic              r_s1_hb_ok;
    logic [HAW-1:0]    r_s1_hist_waddr;
    logic [HAW-1:0]    r_s1_hist_raddr;
    logic [1:0]        r_s1_send;
    logic [15:0]       r_s1_pseq;
    plt_pkg::t_phase   r_s1_phase;

    plt_pkg::t_stats   stats_a;
    plt_pkg::t_stats   stats_b;
    plt_pkg::t_stats   stats_upd;
    plt_pkg::t_stats   stats_rep;
    logic [31:0]       hist_a;
    logic [31:0]       hist_b;
    logic [31:0]       hist_upd;
    logic [31:0]       bin_rep;

    logic               r_out_valid;
    plt_pkg::t_out_item r_out;
    plt_pkg::t_out_item n_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval_ms <= plt_pkg::RST_INTERVAL_MS;
            r_short_timeout_us <= plt_pkg::RST_SHORT_TIMEOUT_US;
            r_long_timeout_us <= plt_pkg::RST_LONG_TIMEOUT_US;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                plt_pkg::CFG_INTERVAL_MS: r_interval_ms <= i_cfg_data[15:0];
                plt_pkg::CFG_SHORT_TIMEOUT_US: r_short_timeout_us <= i_cfg_data;
                plt_pkg::CFG_LONG_TIMEOUT_US: r_long_timeout_us <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake and pipeline control.
    assign s1_adv   = !r_out_valid || o_out.ready;
    assign s1_fire  = r_s1_valid && s1_adv;
    assign in_ready = !r_s1_valid || s1_adv;
    assign accept   = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    assign elapsed = i_in.data.now_us - r_ping_time;
    assign due_gap = i_in.data.now_us - r_next_due;
    assign short_good = i_in.data.frame_ok && i_in.data.pkt_role == plt_pkg::ROLE_PONG
                        && i_in.data.pkt_radio == plt_pkg::RADIO_ID_SHORT
                        && i_in.data.pkt_seq == r_short_seq;
    assign long_good = i_in.data.kind == plt_pkg::KIND_LONG_RX && i_in.data.frame_ok
                       && i_in.data.pkt_role == plt_pkg::ROLE_PONG
                       && i_in.data.pkt_radio == plt_pkg::RADIO_ID_LONG
                       && i_in.data.pkt_seq == r_long_seq;

    // Sequencer next state and the record it hands to the statistics stage.
    always_comb begin
        n_phase = r_phase;
        n_short_seq = r_short_seq;
        n_long_seq = r_long_seq;
        n_ping_time = r_ping_time;
        n_next_due = r_next_due;
        send = plt_pkg::SEND_NONE;
        pseq = '0;
        rec = 1'b0;
        clr = 1'b0;
        rec_radio = plt_pkg::RADIO_SHORT;
        rec_good = 1'b0;
        rec_rtt = elapsed;
        rec_q = '0;
        if (accept) begin
            if (i_in.data.kind <= plt_pkg::KIND_LONG_CRC) begin
                unique case (r_phase)
                    plt_pkg::PH_IDLE: begin
                        if (!due_gap[31]) begin
                            n_phase = plt_pkg::PH_SEND_S;
                        end
                    end
                    plt_pkg::PH_SEND_S: begin
                        send = plt_pkg::SEND_SHORT;
                        pseq = r_short_seq;
                        n_ping_time = i_in.data.now_us;
                        n_phase = plt_pkg::PH_WAIT_S;
                    end
                    plt_pkg::PH_WAIT_S: begin
                        if (i_in.data.kind == plt_pkg::KIND_SHORT_RX
                            || elapsed > r_short_timeout_us) begin
                            rec = 1'b1;
                            rec_radio = plt_pkg::RADIO_SHORT;
                            if (i_in.data.kind == plt_pkg::KIND_SHORT_RX) begin
                                rec_good = short_good;
                                rec_q.rssi = i_in.data.signal_rssi[7:0];
                                rec_q.lqi = short_good ? i_in.data.signal_lqi : 8'd0;
                            end
                            n_short_seq = r_short_seq + 16'd1;
                            n_phase = plt_pkg::PH_SEND_L;
                        end
                    end
                    plt_pkg::PH_SEND_L: begin
                        send = plt_pkg::SEND_LONG;
                        pseq = r_long_seq;
                        n_ping_time = i_in.data.now_us;
                        n_phase = plt_pkg::PH_WAIT_L;
                    end
                    plt_pkg::PH_WAIT_L: begin
                        if (i_in.data.kind == plt_pkg::KIND_LONG_RX
                            || i_in.data.kind == plt_pkg::KIND_LONG_CRC
                            || elapsed > r_long_timeout_us) begin
                            rec = 1'b1;
                            rec_radio = plt_pkg::RADIO_LONG;
                            rec_good = long_good;
                            if (long_good) begin
                                rec_q.rssi = plt_pkg::rssi_div_neg10(i_in.data.signal_rssi);
                                rec_q.snr = i_in.data.signal_snr;
                            end
                            n_long_seq = r_long_seq + 16'd1;
                            n_phase = plt_pkg::PH_IDLE;
                            n_next_due = i_in.data.now_us
                                         + 32'(r_interval_ms) * plt_pkg::US_PER_MS;
                        end
                    end
                    default: n_phase = plt_pkg::PH_IDLE;
                endcase
            end else if (i_in.data.kind == plt_pkg::KIND_RESTART) begin
                n_phase = plt_pkg::PH_IDLE;
                n_short_seq = '0;
                n_long_seq = '0;
                n_next_due = i_in.data.now_us + plt_pkg::RESTART_DELAY_US;
            end else if (i_in.data.kind == plt_pkg::KIND_CLEAR) begin
                clr = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= plt_pkg::PH_IDLE;
            r_short_seq <= '0;
            r_long_seq <= '0;
            r_ping_time <= '0;
            r_next_due <= '0;
        end else begin
            r_phase <= n_phase;
            r_short_seq <= n_short_seq;
            r_long_seq <= n_long_seq;
            r_ping_time <= n_ping_time;
            r_next_due <= n_next_due;
        end
    end

    assign hist_waddr = HAW'(int'(rec_radio) * plt_pkg::HIST_BINS
                             + int'(plt_pkg::rtt_bin(elapsed)));
    assign hist_raddr = HAW'(int'(i_in.data.stats_select) * plt_pkg::HIST_BINS
                             + int'(i_in.data.hist_bin));
    assign hb_ok = int'(i_in.data.hist_bin) < plt_pkg::HIST_BINS;

    // Statistics stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rec <= rec;
            r_s1_clr <= clr;
            r_s1_radio <= rec_radio;
            r_s1_good <= rec_good;
            r_s1_rtt <= rec_rtt;
            r_s1_q <= rec_q;
            r_s1_sel <= SAW'(i_in.data.stats_select);
            r_s1_hb_ok <= hb_ok;
            r_s1_hist_waddr <= hist_waddr;
            r_s1_hist_raddr <= hist_raddr;
            r_s1_send <= send;
            r_s1_pseq <= pseq;
            r_s1_phase <= n_phase;
        end
    end

    plt_ram #(
        .DEPTH (plt_pkg::RADIOS),
        .WIDTH ($bits(plt_pkg::t_stats))
    ) u_stats_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (s1_fire && r_s1_clr),
        .i_we      (s1_fire && r_s1_rec),
        .i_waddr   (r_s1_radio),
        .i_wdata   (stats_upd),
        .i_re      (accept),
        .i_raddr_a (rec_radio),
        .i_raddr_b (SAW'(i_in.data.stats_select)),
        .o_rdata_a (stats_a),
        .o_rdata_b (stats_b)
    );

    plt_ram #(
        .DEPTH (plt_pkg::HIST_DEPTH),
        .WIDTH (32)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (s1_fire && r_s1_clr),
        .i_we      (s1_fire && r_s1_rec && r_s1_good),
        .i_waddr   (r_s1_hist_waddr),
        .i_wdata   (hist_upd),
        .i_re      (accept),
        .i_raddr_a (hist_waddr),
        .i_raddr_b (hist_raddr),
        .o_rdata_a (hist_a),
        .o_rdata_b (hist_b)
    );

    assign hist_upd = hist_a + 32'd1;

    always_comb begin
        stats_upd = stats_a;
        stats_upd.attempts = stats_a.attempts + 32'd1;
        stats_upd.quality = r_s1_q;
        if (r_s1_good) begin
            stats_upd.successes = stats_a.successes + 32'd1;
            if (stats_a.min_trip == '0 || r_s1_rtt < stats_a.min_trip) begin
                stats_upd.min_trip = r_s1_rtt;
            end
            if (r_s1_rtt > stats_a.max_trip) begin
                stats_upd.max_trip = r_s1_rtt;
            end
            stats_upd.trip_sum = stats_a.trip_sum + 64'(r_s1_rtt);
        end

        if (r_s1_clr) begin
            stats_rep = '0;
        end else if (r_s1_rec && r_s1_radio == r_s1_sel) begin
            stats_rep = stats_upd;
        end else begin
            stats_rep = stats_b;
        end

        if (!r_s1_hb_ok || r_s1_clr) begin
            bin_rep = '0;
        end else if (r_s1_rec && r_s1_good && r_s1_hist_raddr == r_s1_hist_waddr) begin
            bin_rep = hist_upd;
        end else begin
            bin_rep = hist_b;
        end

        n_out.send_ping = r_s1_send;
        n_out.ping_seq = r_s1_pseq;
        n_out.link_state = r_s1_phase;
        n_out.total_count = stats_rep.attempts;
        n_out.ok_count = stats_rep.successes;
        n_out.rtt_min = stats_rep.min_trip;
        n_out.rtt_max = stats_rep.max_trip;
        n_out.rtt_total = stats_rep.trip_sum;
        n_out.bin_count = bin_rep;
        n_out.recent_rssi = stats_rep.quality.rssi;
        n_out.recent_snr = stats_rep.quality.snr;
        n_out.recent_lqi = stats_rep.quality.lqi;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data = r_out;
endmodule
`default_nettype wire

// ===== design/plt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ping link test port checker
// Checks the result channel of the ping link test over time.
// ----------------------------------------------------------------------------
module plt_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire plt_pkg::t_out_item i_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result withdrawn before its transfer.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("Result changed while stalled.");

    a_short_ping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.send_ping == plt_pkg::SEND_SHORT
        |-> i_out_data.link_state == 3'(plt_pkg::PH_WAIT_S))
        else $error("Short ping without moving to the short wait.");

    a_long_ping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.send_ping == plt_pkg::SEND_LONG
        |-> i_out_data.link_state == 3'(plt_pkg::PH_WAIT_L))
        else $error("Long ping without moving to the long wait.");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.rtt_min <= i_out_data.rtt_max)
        else $error("Minimum round trip exceeds the maximum.");
endmodule

bind ping_link_test_with_rtt_stats plt_checker u_plt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
`default_nettype wire
